// ----- rtl/lcwf_pkg.sv -----
// ----------------------------------------------------------------------------
// lcwf_pkg
// Shared types, fixed-point constants and the arctangent table of the
// corridor window filter.
// ----------------------------------------------------------------------------
package lcwf_pkg;

  localparam int MAX_RAYS_DEF      = 2048;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 20;
  localparam int WIDTH_W = 16;
  localparam int STEP_W  = 16;
  localparam int TALLY_W = 12;
  localparam int KEPT_W  = 17;
  localparam int ANG_SHIFT = 14;
  localparam int CW      = ANGLE_W + ANG_SHIFT;
  localparam int MAG_W   = 31;
  localparam int PROD_W  = MAG_W + RANGE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 2'd2;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] NEG_PI_Q30  = -34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI_Q30 = -34'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 20'sd524287;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 12'd4095;
  localparam logic signed [KEPT_W-1:0] KEPT_REJECT = -17'sd1;

  typedef struct packed {
    logic [RANGE_W-1:0]        range_reading;
    logic                      scan_end;
    logic signed [ANGLE_W-1:0] angle;
  } ray_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } rot_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] val;
    case (idx)
      0:       val = 34'sd843314857;
      1:       val = 34'sd497837829;
      2:       val = 34'sd263043837;
      3:       val = 34'sd133525159;
      4:       val = 34'sd67021687;
      5:       val = 34'sd33543516;
      6:       val = 34'sd16775851;
      7:       val = 34'sd8388437;
      8:       val = 34'sd4194283;
      9:       val = 34'sd2097149;
      10:      val = 34'sd1048576;
      11:      val = 34'sd524288;
      12:      val = 34'sd262144;
      13:      val = 34'sd131072;
      14:      val = 34'sd65536;
      15:      val = 34'sd32768;
      16:      val = 34'sd16384;
      17:      val = 34'sd8192;
      18:      val = 34'sd4096;
      19:      val = 34'sd2048;
      20:      val = 34'sd1024;
      21:      val = 34'sd512;
      22:      val = 34'sd256;
      23:      val = 34'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/lidar_corridor_window_filter.sv -----
// ----------------------------------------------------------------------------
// lidar_corridor_window_filter
// Corridor window filter for laser scans: one ray per word, with a pipelined
// sine and cosine unit built as a chain of rotation cells.
// ----------------------------------------------------------------------------
// Path from an accepted input word to its output word: input cell, two angle
// folding cells, the rotation cells, then product and output cells.
// Throughput: one word per cycle; each cell stalls only when its successor is
// full and stalled. Reset clears the configuration registers, the ray counter,
// the angle accumulator, the count and all valid flags.
module lidar_corridor_window_filter #(
  parameter int MAX_RAYS      = lcwf_pkg::MAX_RAYS_DEF,
  parameter int CORDIC_STAGES = lcwf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lcwf_pkg::RANGE_W-1:0]           in_range_reading,
  input  logic                                   in_scan_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_ray_ok,
  output logic signed [lcwf_pkg::KEPT_W-1:0]     out_kept_reading,
  output logic signed [lcwf_pkg::ANGLE_W-1:0]    out_ray_angle,
  output logic [lcwf_pkg::TALLY_W-1:0]           out_ok_count,
  output logic                                   out_final_ray,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lcwf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lcwf_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [lcwf_pkg::WIDTH_W-1:0]          corridor_width_r;
  logic signed [lcwf_pkg::ANGLE_W-1:0]   start_angle_r;
  logic [lcwf_pkg::STEP_W-1:0]           angle_step_r;

  logic                                  f_valid, f_ready;
  lcwf_pkg::ray_t                        f_ray;
  logic                                  c_valid [0:CORDIC_STAGES];
  logic                                  c_ready [0:CORDIC_STAGES];
  lcwf_pkg::ray_t                        c_ray   [0:CORDIC_STAGES];
  lcwf_pkg::rot_t                        c_rot   [0:CORDIC_STAGES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corridor_width_r <= '0;
      start_angle_r    <= '0;
      angle_step_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcwf_pkg::REG_CORRIDOR_WIDTH: corridor_width_r <= cfg_data[lcwf_pkg::WIDTH_W-1:0];
        lcwf_pkg::REG_START_ANGLE:    start_angle_r    <= $signed(cfg_data);
        lcwf_pkg::REG_ANGLE_STEP:     angle_step_r     <= cfg_data[lcwf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  lcwf_front #(
    .MAX_RAYS (MAX_RAYS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_range_reading (in_range_reading),
    .in_scan_end      (in_scan_end),
    .start_angle      (start_angle_r),
    .angle_step       (angle_step_r),
    .dn_valid         (f_valid),
    .dn_ready         (f_ready),
    .dn_ray           (f_ray)
  );

  lcwf_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_ray   (f_ray),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_ray   (c_ray[0]),
    .dn_rot   (c_rot[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    lcwf_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_ray   (c_ray[i]),
      .up_rot   (c_rot[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_ray   (c_ray[i+1]),
      .dn_rot   (c_rot[i+1])
    );
  end

  lcwf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (c_valid[CORDIC_STAGES]),
    .up_ready         (c_ready[CORDIC_STAGES]),
    .up_ray           (c_ray[CORDIC_STAGES]),
    .up_rot           (c_rot[CORDIC_STAGES]),
    .corridor_width   (corridor_width_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ray_ok       (out_ray_ok),
    .out_kept_reading (out_kept_reading),
    .out_ray_angle    (out_ray_angle),
    .out_ok_count     (out_ok_count),
    .out_final_ray    (out_final_ray)
  );

endmodule

// ----- rtl/lcwf_front.sv -----
// ----------------------------------------------------------------------------
// lcwf_front
// Input cell: steps the ray angle, counts rays of the scan and registers
// each accepted word.
// ----------------------------------------------------------------------------
module lcwf_front #(
  parameter int MAX_RAYS = lcwf_pkg::MAX_RAYS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [lcwf_pkg::RANGE_W-1:0]            in_range_reading,
  input  logic                                    in_scan_end,
  input  logic signed [lcwf_pkg::ANGLE_W-1:0]     start_angle,
  input  logic [lcwf_pkg::STEP_W-1:0]             angle_step,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output lcwf_pkg::ray_t                          dn_ray
);

  localparam int CNT_W = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RAYS - 1);

  logic [CNT_W-1:0]                       cnt_r, cnt_nxt;
  logic signed [lcwf_pkg::ANGLE_W-1:0]    accum_r, accum_nxt;
  logic                                   v_r;
  lcwf_pkg::ray_t                         ray_r;
  logic signed [lcwf_pkg::ANGLE_W:0]      sum;
  logic signed [lcwf_pkg::ANGLE_W-1:0]    angle;
  logic                                   accept;

  assign in_ready = !v_r || dn_ready;
  assign accept   = in_valid && in_ready;

  assign sum = {accum_r[lcwf_pkg::ANGLE_W-1], accum_r}
             + $signed({1'b0, (lcwf_pkg::ANGLE_W - lcwf_pkg::STEP_W)'(0), angle_step});

  always_comb begin
    if (cnt_r == '0) begin
      angle = start_angle;
    end else if (sum > $signed({1'b0, lcwf_pkg::ANGLE_MAX})) begin
      angle = lcwf_pkg::ANGLE_MAX;
    end else begin
      angle = sum[lcwf_pkg::ANGLE_W-1:0];
    end
    if (in_scan_end) begin
      cnt_nxt   = '0;
      accum_nxt = '0;
    end else begin
      cnt_nxt   = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
      accum_nxt = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      cnt_r   <= '0;
      accum_r <= '0;
    end else begin
      if (in_ready) begin
        v_r <= in_valid;
      end
      if (accept) begin
        cnt_r   <= cnt_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ray_r.range_reading <= in_range_reading;
      ray_r.scan_end      <= in_scan_end;
      ray_r.angle         <= angle;
    end
  end

  assign dn_valid = v_r;
  assign dn_ray   = ray_r;

endmodule

// ----- rtl/lcwf_fold.sv -----
// ----------------------------------------------------------------------------
// lcwf_fold
// Two cells that widen the angle, reduce it into [-pi, pi] and fold it into
// [-pi/2, pi/2], seeding the rotation state.
// ----------------------------------------------------------------------------
module lcwf_fold (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  lcwf_pkg::ray_t up_ray,
  output logic           dn_valid,
  input  logic           dn_ready,
  output lcwf_pkg::ray_t dn_ray,
  output lcwf_pkg::rot_t dn_rot
);

  logic                              v1_r, v2_r, rdy1, rdy2;
  lcwf_pkg::ray_t                    ray1_r, ray2_r;
  logic signed [lcwf_pkg::CW-1:0]    z0, z1_nxt, z1_r;
  lcwf_pkg::rot_t                    rot_nxt, rot_r;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign z0 = {up_ray.angle, lcwf_pkg::ANG_SHIFT'(0)};

  always_comb begin
    if (z0 > lcwf_pkg::PI_Q30) begin
      z1_nxt = z0 - lcwf_pkg::TWO_PI_Q30;
    end else if (z0 < lcwf_pkg::NEG_PI_Q30) begin
      z1_nxt = z0 + lcwf_pkg::TWO_PI_Q30;
    end else begin
      z1_nxt = z0;
    end
  end

  always_comb begin
    rot_nxt.x = lcwf_pkg::GAIN_Q30;
    rot_nxt.y = '0;
    if (z1_r > lcwf_pkg::HALF_PI_Q30) begin
      rot_nxt.z    = z1_r - lcwf_pkg::PI_Q30;
      rot_nxt.flip = 1'b1;
    end else if (z1_r < lcwf_pkg::NEG_HALF_PI_Q30) begin
      rot_nxt.z    = z1_r + lcwf_pkg::PI_Q30;
      rot_nxt.flip = 1'b1;
    end else begin
      rot_nxt.z    = z1_r;
      rot_nxt.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      ray1_r <= up_ray;
      z1_r   <= z1_nxt;
    end
    if (rdy2 && v1_r) begin
      ray2_r <= ray1_r;
      rot_r  <= rot_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_ray   = ray2_r;
  assign dn_rot   = rot_r;

endmodule

// ----- rtl/lcwf_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// lcwf_cordic_cell
// One rotation step of the sine and cosine pipeline with its own handshake.
// ----------------------------------------------------------------------------
module lcwf_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  lcwf_pkg::ray_t up_ray,
  input  lcwf_pkg::rot_t up_rot,
  output logic           dn_valid,
  input  logic           dn_ready,
  output lcwf_pkg::ray_t dn_ray,
  output lcwf_pkg::rot_t dn_rot
);

  localparam logic signed [lcwf_pkg::CW-1:0] ATAN = lcwf_pkg::atan_q30(STAGE);

  logic                              v_r;
  lcwf_pkg::ray_t                    ray_r;
  lcwf_pkg::rot_t                    rot_r, rot_nxt;
  logic signed [lcwf_pkg::CW-1:0]    x, y, z, xs, ys;

  assign up_ready = !v_r || dn_ready;

  assign x  = up_rot.x;
  assign y  = up_rot.y;
  assign z  = up_rot.z;
  assign xs = x >>> STAGE;
  assign ys = y >>> STAGE;

  always_comb begin
    rot_nxt.flip = up_rot.flip;
    if (z >= 0) begin
      rot_nxt.x = x - ys;
      rot_nxt.y = y + xs;
      rot_nxt.z = z - ATAN;
    end else begin
      rot_nxt.x = x + ys;
      rot_nxt.y = y - xs;
      rot_nxt.z = z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ray_r <= up_ray;
      rot_r <= rot_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_ray   = ray_r;
  assign dn_rot   = rot_r;

endmodule

// ----- rtl/lcwf_back.sv -----
// ----------------------------------------------------------------------------
// lcwf_back
// Forms the lateral offset product, applies the corridor test, keeps the
// running count of kept rays and holds the output word.
// ----------------------------------------------------------------------------
module lcwf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  lcwf_pkg::ray_t                       up_ray,
  input  lcwf_pkg::rot_t                       up_rot,
  input  logic [lcwf_pkg::WIDTH_W-1:0]         corridor_width,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_ray_ok,
  output logic signed [lcwf_pkg::KEPT_W-1:0]   out_kept_reading,
  output logic signed [lcwf_pkg::ANGLE_W-1:0]  out_ray_angle,
  output logic [lcwf_pkg::TALLY_W-1:0]         out_ok_count,
  output logic                                 out_final_ray
);

  localparam int CMP_W = lcwf_pkg::PROD_W + 1;

  logic                              va_r, vb_r, rdya, rdyb;
  lcwf_pkg::ray_t                    raya_r;
  logic [lcwf_pkg::PROD_W-1:0]       prod_r;
  logic                              back_r;
  logic signed [lcwf_pkg::CW-1:0]    x, y, ymag;
  logic                              back_nxt;
  logic [CMP_W-1:0]                  lat2, limit;
  logic                              ok;
  logic [lcwf_pkg::TALLY_W-1:0]      tally_r, tally_inc, tally_nxt;

  assign rdyb     = !vb_r || out_ready;
  assign rdya     = !va_r || rdyb;
  assign up_ready = rdya;

  assign x        = up_rot.x;
  assign y        = up_rot.y;
  assign ymag     = (y < 0) ? -y : y;
  assign back_nxt = (up_rot.flip ? (x > 0) : (x < 0)) && (up_ray.range_reading != '0);

  assign lat2  = {prod_r, 1'b0};
  assign limit = {(CMP_W - lcwf_pkg::WIDTH_W - 30)'(0), corridor_width, 30'd0};
  assign ok    = !((corridor_width != '0) && ((lat2 > limit) || back_r));

  assign tally_inc = (ok && (tally_r != lcwf_pkg::TALLY_MAX)) ? tally_r + 1'b1 : tally_r;
  assign tally_nxt = raya_r.scan_end ? '0 : tally_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      tally_r <= '0;
    end else begin
      if (rdya) begin
        va_r <= up_valid;
      end
      if (rdyb) begin
        vb_r <= va_r;
      end
      if (rdyb && va_r) begin
        tally_r <= tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdya && up_valid) begin
      raya_r <= up_ray;
      prod_r <= ymag[lcwf_pkg::MAG_W-1:0] * up_ray.range_reading;
      back_r <= back_nxt;
    end
    if (rdyb && va_r) begin
      out_ray_ok       <= ok;
      out_kept_reading <= ok ? $signed({1'b0, raya_r.range_reading}) : lcwf_pkg::KEPT_REJECT;
      out_ray_angle    <= raya_r.angle;
      out_ok_count     <= tally_inc;
      out_final_ray    <= raya_r.scan_end;
    end
  end

  assign out_valid = vb_r;

endmodule

// ----- dv/lidar_corridor_window_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_corridor_window_filter_tb
// Self-checking bench for the corridor window filter. Scans of rays go in
// through a queue-fed driver while a monitor predicts each result word with
// its own fixed-point rotation model and compares the words that come out.
// Directed scans cover the field extremes, angle saturation, zero range and
// a mid-scan register change. Random phases with fresh register settings
// follow, then one long scan that runs the ray counter into saturation. Both
// sides stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module lidar_corridor_window_filter_tb;

  localparam int RANGE_W    = lcwf_pkg::RANGE_W;
  localparam int ANGLE_W    = lcwf_pkg::ANGLE_W;
  localparam int WIDTH_W    = lcwf_pkg::WIDTH_W;
  localparam int STEP_W     = lcwf_pkg::STEP_W;
  localparam int TALLY_W    = lcwf_pkg::TALLY_W;
  localparam int KEPT_W     = lcwf_pkg::KEPT_W;
  localparam int CFG_IDX_W  = lcwf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lcwf_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_WIDTH = lcwf_pkg::REG_CORRIDOR_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = lcwf_pkg::REG_START_ANGLE;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = lcwf_pkg::REG_ANGLE_STEP;

  localparam int STAGES      = 16;
  localparam int RAY_LIMIT   = 64;
  localparam int SETTLE      = STAGES + 5 + 4;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint PI_FIX      = 64'sd3373259426;
  localparam longint HALF_PI_FIX = 64'sd1686629713;
  localparam longint TWO_PI_FIX  = 64'sd6746518852;
  localparam longint GAIN_FIX    = 64'sd652032874;
  localparam logic signed [ANGLE_W-1:0] ANGLE_TOP    = 20'sd524287;
  localparam logic signed [ANGLE_W-1:0] ANGLE_BOTTOM = -20'sd524288;
  localparam logic [TALLY_W-1:0] TALLY_TOP = 12'd4095;

  typedef struct packed {
    logic [RANGE_W-1:0] rng;
    logic               last;
  } ray_in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [KEPT_W-1:0]  kept;
    logic signed [ANGLE_W-1:0] angle;
    logic [TALLY_W-1:0]        count;
    logic                      last;
  } ray_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RANGE_W-1:0] in_range_reading = '0;
  logic in_scan_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ray_ok;
  logic signed [KEPT_W-1:0] out_kept_reading;
  logic signed [ANGLE_W-1:0] out_ray_angle;
  logic [TALLY_W-1:0] out_ok_count;
  logic out_final_ray;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lidar_corridor_window_filter #(
    .MAX_RAYS(RAY_LIMIT),
    .CORDIC_STAGES(STAGES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_range_reading(in_range_reading),
    .in_scan_end(in_scan_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ray_ok(out_ray_ok),
    .out_kept_reading(out_kept_reading),
    .out_ray_angle(out_ray_angle),
    .out_ok_count(out_ok_count),
    .out_final_ray(out_final_ray),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  longint atan_tab [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // Register shadow and scan state of the predictor.
  logic [WIDTH_W-1:0] corridor_r = '0;
  logic signed [ANGLE_W-1:0] start_r = '0;
  logic [STEP_W-1:0] step_r = '0;
  logic signed [ANGLE_W-1:0] angle_acc = '0;
  logic [10:0] ray_cnt = '0;
  logic [TALLY_W-1:0] tally = '0;

  ray_in_t pending_rays [$];
  ray_res_t expected_rays [$];
  ray_in_t next_ray;
  ray_res_t got_ray;
  ray_res_t want_ray;

  int n_queued = 0;
  int n_offered = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_scans = 0;
  int n_rejected = 0;
  int n_writes = 0;
  int n_fail = 0;
  int cycles = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_ray(input logic [RANGE_W-1:0] rng, input logic last);
    logic signed [ANGLE_W-1:0] ang;
    longint a;
    longint z;
    longint x;
    longint y;
    longint t;
    longint ly;
    longint lx;
    bit flip;
    bit ok;
    ray_res_t r;
    if (ray_cnt == 0) begin
      ang = start_r;
    end else begin
      a = longint'(angle_acc) + longint'(step_r);
      ang = (a > ANGLE_TOP) ? ANGLE_TOP : a[ANGLE_W-1:0];
    end
    angle_acc = ang;

    z = longint'(ang) * 16384;
    x = GAIN_FIX;
    y = 0;
    flip = 1'b0;
    while (z > PI_FIX) z -= TWO_PI_FIX;
    while (z < -PI_FIX) z += TWO_PI_FIX;
    if (z > HALF_PI_FIX) begin
      z -= PI_FIX;
      flip = 1'b1;
    end else if (z < -HALF_PI_FIX) begin
      z += PI_FIX;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end

    ly = y * longint'(rng);
    lx = x * longint'(rng);
    if (ly < 0) ly = -ly;
    ok = !(corridor_r != 0 && (2 * ly > (longint'(corridor_r) << 30) || lx < 0));

    if (ok && tally < TALLY_TOP) tally++;
    if (ray_cnt < RAY_LIMIT - 1) ray_cnt++;

    r.ok = ok;
    r.kept = ok ? {1'b0, rng} : '1;
    r.angle = ang;
    r.count = tally;
    r.last = last;
    expected_rays.insert(expected_rays.size(), r);

    if (last) begin
      ray_cnt = '0;
      tally = '0;
      angle_acc = '0;
    end
  endfunction

  task automatic queue_ray(input logic [RANGE_W-1:0] rng, input logic last);
    pending_rays.insert(pending_rays.size(), '{rng: rng, last: last});
    n_queued++;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return RANGE_W'($urandom_range(0, 255));
      default: return RANGE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CORRIDOR_WIDTH: corridor_r = data[WIDTH_W-1:0];
      REG_START_ANGLE: start_r = data;
      REG_ANGLE_STEP: step_r = data[STEP_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (n_accepted != n_queued || expected_rays.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Input driver.
  always @(negedge clk) begin
    if (!in_valid || n_accepted == n_offered) begin
      if (rst_n && pending_rays.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        next_ray = pending_rays.pop_front();
        n_offered++;
        in_valid <= 1'b1;
        in_range_reading <= next_ray.rng;
        in_scan_end <= next_ray.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and requested long hold-offs.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // Monitor: predicts on each accepted ray word and checks each result word.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, expected_rays.size());
      $display("lidar_corridor_window_filter_tb NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_ray(in_range_reading, in_scan_end);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        got_ray.ok = out_ray_ok;
        got_ray.kept = out_kept_reading;
        got_ray.angle = out_ray_angle;
        got_ray.count = out_ok_count;
        got_ray.last = out_final_ray;
        if (expected_rays.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("Unexpected result word: ok=%0d kept=%0d angle=%0d count=%0d final=%0d",
                     got_ray.ok, got_ray.kept, got_ray.angle, got_ray.count, got_ray.last);
        end else begin
          want_ray = expected_rays.pop_front();
          if (got_ray.ok !== want_ray.ok || got_ray.kept !== want_ray.kept ||
              got_ray.angle !== want_ray.angle || got_ray.count !== want_ray.count ||
              got_ray.last !== want_ray.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("Ray %0d mismatch: expected ok=%0d kept=%0d angle=%0d count=%0d final=%0d,",
                       n_checked, want_ray.ok, want_ray.kept, want_ray.angle,
                       want_ray.count, want_ray.last);
              $display("  got ok=%0d kept=%0d angle=%0d count=%0d final=%0d",
                       got_ray.ok, got_ray.kept, got_ray.angle, got_ray.count, got_ray.last);
            end
          end
          n_checked++;
          if (want_ray.last) n_scans++;
          if (!want_ray.ok) n_rejected++;
        end
      end
    end
  end

  initial begin
    int target;
    int len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the window is off, so every ray is kept.
    queue_ray(16'd0, 1'b0);
    queue_ray(16'hFFFF, 1'b0);
    queue_ray(16'h8000, 1'b1);
    drain();

    // Lowest start angle with the widest step sweeps more than one turn.
    write_reg(REG_CORRIDOR_WIDTH, {4'hF, 16'd1000});
    write_reg(REG_START_ANGLE, ANGLE_BOTTOM);
    write_reg(REG_ANGLE_STEP, 20'h0FFFF);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
    end_writes();
    queue_ray(16'hFFFF, 1'b0);
    queue_ray(16'd0, 1'b0);
    queue_ray(16'd1, 1'b0);
    queue_ray(16'd40000, 1'b0);
    queue_ray(16'd12345, 1'b0);
    queue_ray(16'hFFFF, 1'b0);
    queue_ray(16'd7, 1'b0);
    queue_ray(16'd30000, 1'b1);
    drain();

    // Start near the top so that the angle saturates; scan left open.
    write_reg(REG_CORRIDOR_WIDTH, 20'hFFFFF);
    write_reg(REG_START_ANGLE, 20'sd524000);
    end_writes();
    queue_ray(16'hFFFF, 1'b0);
    queue_ray(16'd0, 1'b0);
    queue_ray(16'h8000, 1'b0);
    queue_ray(16'd1, 1'b0);
    drain();

    // New settings in the middle of the scan.
    write_reg(REG_CORRIDOR_WIDTH, {4'hA, 16'd1});
    write_reg(REG_START_ANGLE, 20'd0);
    write_reg(REG_ANGLE_STEP, {4'h5, 16'd100});
    end_writes();
    queue_ray(16'd0, 1'b0);
    queue_ray(16'd5000, 1'b1);
    queue_ray(16'd5000, 1'b1);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_CORRIDOR_WIDTH, {4'($urandom), 16'd0});
          1: write_reg(REG_CORRIDOR_WIDTH, {4'($urandom), 16'd1});
          2: write_reg(REG_CORRIDOR_WIDTH, {4'($urandom), 16'hFFFF});
          3: write_reg(REG_CORRIDOR_WIDTH, {4'($urandom), 16'($urandom)});
          default: write_reg(REG_CORRIDOR_WIDTH,
                             {4'($urandom), 16'($urandom_range(0, 20000))});
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_START_ANGLE, ANGLE_BOTTOM);
          1: write_reg(REG_START_ANGLE, ANGLE_TOP);
          default: write_reg(REG_START_ANGLE, CFG_DATA_W'($urandom));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 4))
          0: write_reg(REG_ANGLE_STEP, {4'($urandom), 16'd0});
          1: write_reg(REG_ANGLE_STEP, {4'($urandom), 16'hFFFF});
          2: write_reg(REG_ANGLE_STEP, {4'($urandom), 16'($urandom)});
          default: write_reg(REG_ANGLE_STEP,
                             {4'($urandom), 16'($urandom_range(0, 3000))});
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      end_writes();

      calm = (phase == 3);
      if (phase == 6) hold_reqs++;
      target = (phase == 6) ? 200 : 80;
      while (target > 0) begin
        len = $urandom_range(1, 40);
        if (len > target) len = target;
        target -= len;
        for (int k = 0; k < len; k++)
          queue_ray(pick_range(), k == len - 1 && (target != 0 || $urandom_range(0, 2) != 0));
      end
      drain();
      calm = 1'b0;
    end

    // One scan long enough to saturate the ray counter.
    write_reg(REG_CORRIDOR_WIDTH, 20'd0);
    write_reg(REG_ANGLE_STEP, 20'd300);
    end_writes();
    for (int k = 0; k < 100; k++)
      queue_ray(pick_range(), 1'b0);
    queue_ray(pick_range(), 1'b1);
    drain();

    $display("Checked %0d rays over %0d closed scans, %0d of them rejected by the window.",
             n_checked, n_scans, n_rejected);
    $display("Made %0d register writes, including a long receiver hold-off and a 101-ray scan.",
             n_writes);
    if (n_fail == 0) begin
      $display("lidar_corridor_window_filter_tb OK");
    end else begin
      $display("%0d failures.", n_fail);
      $display("lidar_corridor_window_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lcwf_pkg.sv
rtl/lcwf_front.sv
rtl/lcwf_fold.sv
rtl/lcwf_cordic_cell.sv
rtl/lcwf_back.sv
rtl/lidar_corridor_window_filter.sv
dv/lidar_corridor_window_filter_tb.sv
